### sv/smrp_pkg.sv
// Shared constants, types and helper functions for the rigid shape-matching core.
// No dependencies; imported by every module of the block.
package smrp_pkg;

  localparam int MAX_SPHERES = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
  localparam int CNT_W       = $clog2(MAX_SPHERES + 1);
  localparam int MASS_W      = 40;
  localparam int DIV_STEPS   = 64 + FRAC_BITS;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);

  localparam logic [63:0] LIM48  = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM32  = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] LIMBIG = 64'h1000_0000_0000_0000;

  localparam logic [3:0] ORTHO_RESET = 4'd5;
  localparam logic [1:0] COL_TRANSLATION = 2'd3;

  localparam logic KIND_COLUMN   = 1'b0;
  localparam logic KIND_PARTICLE = 1'b1;

  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [2:0][31:0] rest;
    logic [31:0]      mass;
  } particle_t;

  typedef struct packed {
    logic               go;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic [63:0]        lim;
  } arith_req_t;

  typedef struct packed {
    logic               done;
    logic signed [63:0] res;
  } arith_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CEN_RD,
    ST_CEN_MUL,
    ST_CEN_DIV,
    ST_COV_RD,
    ST_COV_MUL1,
    ST_COV_MUL2,
    ST_WM_DIV,
    ST_COF_MUL1,
    ST_COF_MUL2,
    ST_DET_MUL,
    ST_IT_DIV,
    ST_EMIT_COL,
    ST_PRJ_RD,
    ST_PRJ_MUL
  } state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sat(input logic signed [64:0] v,
                                             input logic [63:0] lim);
    logic signed [64:0] l;
    logic signed [64:0] o;
    l = $signed({1'b0, lim});
    if (v > l) o = l;
    else if (v < -l) o = -l;
    else o = v;
    return o[63:0];
  endfunction

  function automatic logic [3:0] idx3(input logic [1:0] row, input logic [1:0] col);
    return 4'({row, 1'b0}) + 4'(row) + 4'(col);
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] v);
    return (v == 2'd2) ? 2'd0 : v + 2'd1;
  endfunction

  function automatic logic [1:0] prv3(input logic [1:0] v);
    return (v == 2'd0) ? 2'd2 : v - 2'd1;
  endfunction

endpackage

### sv/smrp_store.sv
// Particle store: one row per particle (position, rest centre, mass).
// Registered read port; depends on smrp_pkg.
module smrp_store (
  input  logic                       clk,
  input  logic                       we,
  input  logic [smrp_pkg::IDX_W-1:0] waddr,
  input  smrp_pkg::particle_t        wdata,
  input  logic [smrp_pkg::IDX_W-1:0] raddr,
  output smrp_pkg::particle_t        rdata
);
  import smrp_pkg::*;

  particle_t mem [MAX_SPHERES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/smrp_mul.sv
// Shared fixed-point multiplier: (a*b) >> FRAC_BITS, saturated, sign-magnitude.
// One 32x32 partial product per cycle; depends on smrp_pkg.
module smrp_mul (
  input  logic                 clk,
  input  logic                 rst,
  input  smrp_pkg::arith_req_t req,
  output smrp_pkg::arith_rsp_t rsp
);
  import smrp_pkg::*;

  logic         run;
  logic [2:0]   cnt;
  logic [63:0]  ma, mb, lim;
  logic         neg;
  logic [63:0]  pp;
  logic [127:0] acc;
  logic [127:0] pp_sh;
  logic [127-FRAC_BITS:0] shifted;
  logic [63:0]  mres;

  always_comb begin
    unique case (cnt)
      3'd1:    pp_sh = {64'b0, pp};
      3'd2,
      3'd3:    pp_sh = {32'b0, pp, 32'b0};
      default: pp_sh = {pp, 64'b0};
    endcase
    shifted = acc[127:FRAC_BITS];
    mres    = (shifted > (128 - FRAC_BITS)'(lim)) ? lim : shifted[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go && !run) begin
        run <= 1'b1;
        cnt <= '0;
        ma  <= mag64(req.a);
        mb  <= mag64(req.b);
        neg <= req.a[63] ^ req.b[63];
        lim <= req.lim;
        acc <= '0;
      end else if (run) begin
        unique case (cnt)
          3'd0:    pp <= ma[31:0] * mb[31:0];
          3'd1:    pp <= ma[31:0] * mb[63:32];
          3'd2:    pp <= ma[63:32] * mb[31:0];
          3'd3:    pp <= ma[63:32] * mb[63:32];
          default: pp <= pp;
        endcase
        if (cnt != 3'd0 && cnt <= 3'd4) begin
          acc <= acc + pp_sh;
        end
        if (cnt == 3'd5) begin
          run      <= 1'b0;
          rsp.done <= 1'b1;
          rsp.res  <= neg ? -$signed(mres) : $signed(mres);
        end
        cnt <= cnt + 3'd1;
      end
    end
  end

endmodule

### sv/smrp_div.sv
// Shared restoring divider: (num << FRAC_BITS) / den toward zero, saturated.
// One quotient bit per cycle; depends on smrp_pkg.
module smrp_div (
  input  logic                 clk,
  input  logic                 rst,
  input  smrp_pkg::arith_req_t req,
  output smrp_pkg::arith_rsp_t rsp
);
  import smrp_pkg::*;

  logic                 run;
  logic [DIV_CNT_W-1:0] cnt;
  logic [63:0]          num_sh, den, rem, lim;
  logic                 neg;
  logic [DIV_STEPS-1:0] q;
  logic [63:0]          rem_s;
  logic [63:0]          qres;

  always_comb begin
    rem_s = {rem[62:0], num_sh[63]};
    qres  = (q > DIV_STEPS'(lim)) ? lim : q[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run      <= 1'b0;
      cnt      <= '0;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      if (req.go && !run) begin
        run    <= 1'b1;
        cnt    <= '0;
        num_sh <= mag64(req.a);
        den    <= mag64(req.b);
        neg    <= req.a[63] ^ req.b[63];
        lim    <= req.lim;
        rem    <= '0;
        q      <= '0;
      end else if (run) begin
        if (cnt == DIV_CNT_W'(DIV_STEPS)) begin
          run      <= 1'b0;
          rsp.done <= 1'b1;
          rsp.res  <= neg ? -$signed(qres) : $signed(qres);
        end else begin
          num_sh <= {num_sh[62:0], 1'b0};
          if (rem_s >= den) begin
            rem <= rem_s - den;
            q   <= {q[DIV_STEPS-2:0], 1'b1};
          end else begin
            rem <= rem_s;
            q   <= {q[DIV_STEPS-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

### sv/shape_matching_rigid_projection_core.sv
// Top level of the rigid shape-matching core: sequencer, matrix registers, outputs.
// Depends on smrp_pkg, smrp_store, smrp_mul and smrp_div.
//
// Usage: each particle is one transaction, accepted on a rising edge with start
// high and busy low; a particle without last leaves busy low. The particle
// with last high starts the fit and busy rises until the final result is out.
// Results come out on result_strobe, one cycle each: four column results
// (rotation columns 0..2, translation 3) then one projected position per
// stored particle; final_res marks the last. The receiver cannot stall.
// All multiplications go through one multiplier (four 32x32 partial products
// per product) and all divisions through one divider.
// The cfg channel writes ortho_iterations and is ready only while idle.
// Reset (synchronous) empties the particle list, zeroes the mass total and
// sets ortho_iterations to 5; stored particle rows are not cleared.
// Zero total mass or a singular matrix gives error=1 with zero values.
module shape_matching_rigid_projection_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] pos_x,
  input  logic signed [31:0] pos_y,
  input  logic signed [31:0] pos_z,
  input  logic [31:0]        mass,
  input  logic signed [31:0] rest_x,
  input  logic signed [31:0] rest_y,
  input  logic signed [31:0] rest_z,
  input  logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_data,
  output logic               result_strobe,
  output logic               kind,
  output logic [4:0]         index,
  output logic signed [31:0] value_x,
  output logic signed [31:0] value_y,
  output logic signed [31:0] value_z,
  output logic               error,
  output logic               final_res
);
  import smrp_pkg::*;

  state_t              state, state_next;
  logic                pend;
  logic [CNT_W-1:0]    count;
  logic [MASS_W-1:0]   total_mass;
  logic [3:0]          ortho_iterations;
  logic                err;
  logic [IDX_W-1:0]    i, last_idx;
  logic [1:0]          r, c, cc;
  logic [3:0]          it, k;
  logic signed [63:0]  acc, tmp, acc_sum;
  logic signed [47:0]  det, det_sum, cov_sum, cof_diff;
  logic signed [31:0]  cen [3];
  logic signed [31:0]  vout [3];
  logic signed [47:0]  wm [9];
  logic signed [47:0]  cof [9];
  logic [48:0]         hsum, hq;
  logic signed [31:0]  prj_v, col_x, col_y, col_z;
  logic                accept, last_i, c_end, rc_end, md, dd;
  particle_t           wrow, row;
  arith_req_t          mreq, dreq;
  arith_rsp_t          mrsp, drsp;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign last_idx  = IDX_W'(count - 1'b1);
  assign last_i    = (i == last_idx);
  assign c_end     = (c == 2'd2);
  assign rc_end    = c_end && (r == 2'd2);
  assign k         = idx3(r, c);
  assign md        = mrsp.done;
  assign dd        = drsp.done;

  assign wrow.pos  = {pos_z, pos_y, pos_x};
  assign wrow.rest = {rest_z, rest_y, rest_x};
  assign wrow.mass = mass;

  smrp_store u_store (
    .clk   (clk),
    .we    (accept && (count < CNT_W'(MAX_SPHERES))),
    .waddr (count[IDX_W-1:0]),
    .wdata (wrow),
    .raddr (i),
    .rdata (row)
  );

  smrp_mul u_mul (.clk(clk), .rst(rst), .req(mreq), .rsp(mrsp));
  smrp_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  always_comb begin
    acc_sum  = sat(65'(acc) + 65'(mrsp.res), LIMBIG);
    cov_sum  = 48'(sat(65'(cof[k]) + 65'(mrsp.res), LIM48));
    det_sum  = 48'(sat(65'(det) + 65'(mrsp.res), LIM48));
    cof_diff = 48'(sat(65'(tmp) - 65'(mrsp.res), LIM48));
    hsum     = 49'(wm[k]) + 49'(drsp.res);
    hq       = hsum + 49'(hsum[48]);
    prj_v    = 32'(sat(65'(acc_sum) + 65'(cen[r]), LIM32));
    cc       = (c == COL_TRANSLATION) ? 2'd0 : c;
    if (c == COL_TRANSLATION) begin
      col_x = cen[0];
      col_y = cen[1];
      col_z = cen[2];
    end else begin
      col_x = 32'(sat(65'(wm[idx3(2'd0, cc)]), LIM32));
      col_y = 32'(sat(65'(wm[idx3(2'd1, cc)]), LIM32));
      col_z = 32'(sat(65'(wm[idx3(2'd2, cc)]), LIM32));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    mreq       = '0;
    dreq       = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept && last) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = (total_mass == '0) ? ST_EMIT_COL : ST_CEN_RD;
      end
      ST_CEN_RD: state_next = ST_CEN_MUL;
      ST_CEN_MUL: begin
        mreq.go  = !pend;
        mreq.a   = 64'(signed'(row.pos[r]));
        mreq.b   = {32'b0, row.mass};
        mreq.lim = LIMBIG;
        if (md) state_next = last_i ? ST_CEN_DIV : ST_CEN_RD;
      end
      ST_CEN_DIV: begin
        dreq.go  = !pend;
        dreq.a   = acc;
        dreq.b   = {{(64 - MASS_W){1'b0}}, total_mass};
        dreq.lim = LIM32;
        if (dd) state_next = (r == 2'd2) ? ST_COV_RD : ST_CEN_RD;
      end
      ST_COV_RD: state_next = ST_COV_MUL1;
      ST_COV_MUL1: begin
        mreq.go  = !pend;
        mreq.a   = 64'(signed'(row.pos[r])) - 64'(cen[r]);
        mreq.b   = 64'(signed'(row.rest[c]));
        mreq.lim = LIMBIG;
        if (md) state_next = ST_COV_MUL2;
      end
      ST_COV_MUL2: begin
        mreq.go  = !pend;
        mreq.a   = tmp;
        mreq.b   = {32'b0, row.mass};
        mreq.lim = LIM48;
        if (md) begin
          if (!rc_end) state_next = ST_COV_MUL1;
          else state_next = last_i ? ST_WM_DIV : ST_COV_RD;
        end
      end
      ST_WM_DIV: begin
        dreq.go  = !pend;
        dreq.a   = 64'(cof[k]);
        dreq.b   = {{(64 - MASS_W){1'b0}}, total_mass};
        dreq.lim = LIM48;
        if (dd && rc_end) state_next = ST_COF_MUL1;
      end
      ST_COF_MUL1: begin
        mreq.go  = !pend;
        mreq.a   = 64'(wm[idx3(nxt3(r), nxt3(c))]);
        mreq.b   = 64'(wm[idx3(prv3(r), prv3(c))]);
        mreq.lim = LIM48;
        if (md) state_next = ST_COF_MUL2;
      end
      ST_COF_MUL2: begin
        mreq.go  = !pend;
        mreq.a   = 64'(wm[idx3(nxt3(r), prv3(c))]);
        mreq.b   = 64'(wm[idx3(prv3(r), nxt3(c))]);
        mreq.lim = LIM48;
        if (md) state_next = rc_end ? ST_DET_MUL : ST_COF_MUL1;
      end
      ST_DET_MUL: begin
        mreq.go  = !pend;
        mreq.a   = 64'(wm[idx3(2'd0, c)]);
        mreq.b   = 64'(cof[idx3(2'd0, c)]);
        mreq.lim = LIM48;
        if (md && c_end) begin
          if (det_sum == '0 || it == ortho_iterations) state_next = ST_EMIT_COL;
          else state_next = ST_IT_DIV;
        end
      end
      ST_IT_DIV: begin
        dreq.go  = !pend;
        dreq.a   = 64'(cof[k]);
        dreq.b   = 64'(det);
        dreq.lim = LIM48;
        if (dd && rc_end) begin
          state_next = (it + 4'd1 == ortho_iterations) ? ST_EMIT_COL : ST_COF_MUL1;
        end
      end
      ST_EMIT_COL: begin
        if (c == COL_TRANSLATION) begin
          if (count == '0) state_next = ST_IDLE;
          else state_next = err ? ST_PRJ_RD : ST_PRJ_RD;
        end
      end
      ST_PRJ_RD: begin
        if (err) begin
          state_next = last_i ? ST_IDLE : ST_PRJ_RD;
        end else begin
          state_next = ST_PRJ_MUL;
        end
      end
      ST_PRJ_MUL: begin
        mreq.go  = !pend;
        mreq.a   = 64'(wm[k]);
        mreq.b   = 64'(signed'(row.rest[c]));
        mreq.lim = LIMBIG;
        if (md && rc_end) state_next = last_i ? ST_IDLE : ST_PRJ_RD;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend             <= 1'b0;
      count            <= '0;
      total_mass       <= '0;
      ortho_iterations <= ORTHO_RESET;
      err              <= 1'b0;
      result_strobe    <= 1'b0;
      i                <= '0;
      r                <= '0;
      c                <= '0;
      it               <= '0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) ortho_iterations <= cfg_data;
      if (mreq.go || dreq.go) pend <= 1'b1;
      else if (md || dd) pend <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count < CNT_W'(MAX_SPHERES)) begin
              count      <= count + 1'b1;
              total_mass <= total_mass + MASS_W'(mass);
            end
            if (last) begin
              i   <= '0;
              r   <= '0;
              c   <= '0;
              it  <= '0;
              acc <= '0;
              err <= 1'b0;
              for (int j = 0; j < 9; j++) cof[j] <= '0;
            end
          end
        end
        ST_CHECK: begin
          if (total_mass == '0) err <= 1'b1;
        end
        ST_CEN_MUL: begin
          if (md) begin
            acc <= acc_sum;
            if (!last_i) i <= i + 1'b1;
          end
        end
        ST_CEN_DIV: begin
          if (dd) begin
            cen[r] <= drsp.res[31:0];
            acc    <= '0;
            i      <= '0;
            r      <= nxt3(r);
          end
        end
        ST_COV_MUL1: begin
          if (md) tmp <= mrsp.res;
        end
        ST_COV_MUL2: begin
          if (md) begin
            cof[k] <= cov_sum;
            c      <= nxt3(c);
            if (c_end) r <= nxt3(r);
            if (rc_end && !last_i) i <= i + 1'b1;
          end
        end
        ST_WM_DIV: begin
          if (dd) begin
            wm[k] <= 48'(drsp.res);
            c     <= nxt3(c);
            if (c_end) r <= nxt3(r);
          end
        end
        ST_COF_MUL1: begin
          if (md) tmp <= mrsp.res;
        end
        ST_COF_MUL2: begin
          if (md) begin
            cof[k] <= cof_diff;
            c      <= nxt3(c);
            if (c_end) r <= nxt3(r);
            if (rc_end) det <= '0;
          end
        end
        ST_DET_MUL: begin
          if (md) begin
            det <= det_sum;
            c   <= nxt3(c);
            if (c_end && det_sum == '0) err <= 1'b1;
          end
        end
        ST_IT_DIV: begin
          if (dd) begin
            wm[k] <= hq[48:1];
            c     <= nxt3(c);
            if (c_end) r <= nxt3(r);
            if (rc_end) it <= it + 4'd1;
          end
        end
        ST_EMIT_COL: begin
          result_strobe <= 1'b1;
          kind          <= KIND_COLUMN;
          index         <= 5'(c);
          value_x       <= err ? '0 : col_x;
          value_y       <= err ? '0 : col_y;
          value_z       <= err ? '0 : col_z;
          error         <= err;
          final_res     <= (c == COL_TRANSLATION) && (count == '0);
          if (c == COL_TRANSLATION) begin
            c   <= '0;
            r   <= '0;
            i   <= '0;
            acc <= '0;
            if (count == '0) total_mass <= '0;
          end else begin
            c <= c + 2'd1;
          end
        end
        ST_PRJ_RD: begin
          if (err) begin
            result_strobe <= 1'b1;
            kind          <= KIND_PARTICLE;
            index         <= 5'(i);
            value_x       <= '0;
            value_y       <= '0;
            value_z       <= '0;
            error         <= 1'b1;
            final_res     <= last_i;
            if (last_i) begin
              count      <= '0;
              total_mass <= '0;
            end else begin
              i <= i + 1'b1;
            end
          end
        end
        ST_PRJ_MUL: begin
          if (md) begin
            c <= nxt3(c);
            if (c_end) begin
              r       <= nxt3(r);
              vout[r] <= prj_v;
              acc     <= '0;
            end else begin
              acc <= acc_sum;
            end
            if (rc_end) begin
              result_strobe <= 1'b1;
              kind          <= KIND_PARTICLE;
              index         <= 5'(i);
              value_x       <= vout[0];
              value_y       <= vout[1];
              value_z       <= prj_v;
              error         <= 1'b0;
              final_res     <= last_i;
              if (last_i) begin
                count      <= '0;
                total_mass <= '0;
              end else begin
                i <= i + 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_final_ends_run: assert property (@(posedge clk) disable iff (rst)
    result_strobe && final_res |-> !busy)
    else $error("final result while still busy");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result_strobe && error |-> value_x == 0 && value_y == 0 && value_z == 0)
    else $error("error result carries nonzero value");

  a_error_steady: assert property (@(posedge clk) disable iff (rst)
    result_strobe && $past(result_strobe) && !$past(final_res) |-> error == $past(error))
    else $error("error flag changed within a run");

  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !final_res |-> busy)
    else $error("non-final result outside a fit");
`endif

endmodule
